// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on aclk, off while reset is asserted.
`define BDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication.
`define BDQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bdq_pkg.sv
// Shared constants, types and codes for the bounded deque.
`default_nettype none

package bdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // fixed field widths of the transaction payloads
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_READ_AT    = 3'd4,
        MODE_REMOVE_AT  = 3'd5
    } mode_e;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_e;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] value_in;
        logic [POS_W-1:0]   position;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value_out;
        status_e            status;
        logic [COUNT_W-1:0] count;
    } res_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic [IDX_W-1:0]      raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// File: rtl/core/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bdq_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32,
    parameter int WORDS  = 16
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/bdq_agen.sv
// Shared slot address unit: (front + offset) modulo DEPTH.
`default_nettype none

module bdq_agen (
    input  logic [bdq_pkg::IDX_W-1:0] front,
    input  logic [bdq_pkg::IDX_W-1:0] offset,
    output logic [bdq_pkg::IDX_W-1:0] slot
);

    import bdq_pkg::*;

    localparam logic [IDX_W:0] DEPTH_EXT = (IDX_W + 1)'(DEPTH);

    logic [IDX_W:0] sum_raw;
    logic [IDX_W:0] sum_wrap;

    // both operands are below DEPTH, so one conditional subtract wraps it
    always_comb begin
        sum_raw  = {1'b0, front} + {1'b0, offset};
        sum_wrap = (sum_raw >= DEPTH_EXT) ? (sum_raw - DEPTH_EXT) : sum_raw;
    end

    assign slot = sum_wrap[IDX_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/bdq_ctrl.sv
// Sequencer and state registers of the deque: decode, memory access, gap shifting, result register.
`default_nettype none

module bdq_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  bdq_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output bdq_pkg::res_item_t             m_data,
    output logic [bdq_pkg::IDX_W-1:0]      agen_front,
    output logic [bdq_pkg::IDX_W-1:0]      agen_offset,
    input  logic [bdq_pkg::IDX_W-1:0]      agen_slot,
    output bdq_pkg::mem_req_t              mem_req,
    input  logic [bdq_pkg::DATA_WIDTH-1:0] mem_rdata
);

    import bdq_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int STEP_W = CNT_W + 1;

    state_t                state_reg, state_next;
    in_item_t              req_reg, req_next;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      k_reg, k_next;
    logic [DATA_WIDTH-1:0] result_reg, result_next;
    status_e               status_reg, status_next;
    logic                  out_valid_reg, out_valid_next;
    res_item_t             out_data_reg, out_data_next;

    mode_e      req_mode;
    logic       is_empty;
    logic       is_full;
    logic       pos_ok;
    logic       more_rd;
    logic       more_wr;
    logic       out_free;

    assign req_mode = mode_e'(req_reg.mode);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign pos_ok   = (CMP_W'(req_reg.position) < CMP_W'(count_reg));
    // entries behind the removed one still to move up
    assign more_rd  = ((STEP_W'(k_reg) + STEP_W'(1)) < STEP_W'(count_reg));
    assign more_wr  = ((STEP_W'(k_reg) + STEP_W'(2)) < STEP_W'(count_reg));
    assign out_free = !out_valid_reg || m_ready;

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = out_valid_reg;
    assign m_data     = out_data_reg;
    assign agen_front = front_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (req_mode)
                    MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                        state_next = S_DONE;
                    end
                    MODE_POP_FRONT, MODE_POP_BACK: begin
                        state_next = is_empty ? S_DONE : S_RD_WAIT;
                    end
                    MODE_READ_AT, MODE_REMOVE_AT: begin
                        state_next = pos_ok ? S_RD_WAIT : S_DONE;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RD_WAIT: begin
                state_next = (req_mode == MODE_REMOVE_AT && more_rd) ? S_SH_RD : S_DONE;
            end
            S_SH_RD: begin
                state_next = S_SH_WR;
            end
            S_SH_WR: begin
                state_next = more_wr ? S_SH_RD : S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        req_next       = req_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        result_next    = result_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        agen_offset    = '0;
        mem_req.we     = 1'b0;
        mem_req.waddr  = agen_slot;
        mem_req.raddr  = agen_slot;
        mem_req.wdata  = DATA_WIDTH'(req_reg.value_in);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next    = s_data;
                    result_next = '0;
                    status_next = STAT_OK;
                end
            end
            S_EXEC: begin
                unique case (req_mode)
                    MODE_PUSH_FRONT: begin
                        if (is_full) begin
                            status_next = STAT_FULL;
                        end else begin
                            agen_offset = IDX_W'(DEPTH - 1);
                            mem_req.we  = 1'b1;
                            front_next  = agen_slot;
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    MODE_PUSH_BACK: begin
                        if (is_full) begin
                            status_next = STAT_FULL;
                        end else begin
                            agen_offset = IDX_W'(count_reg);
                            mem_req.we  = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    MODE_POP_FRONT: begin
                        if (is_empty) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    MODE_POP_BACK: begin
                        if (is_empty) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            agen_offset = IDX_W'(count_reg - CNT_W'(1));
                            count_next  = count_reg - CNT_W'(1);
                        end
                    end
                    MODE_READ_AT, MODE_REMOVE_AT: begin
                        if (!pos_ok) begin
                            status_next = STAT_RANGE;
                        end else begin
                            agen_offset = IDX_W'(req_reg.position);
                            k_next      = IDX_W'(req_reg.position);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RD_WAIT: begin
                result_next = mem_rdata;
                if (req_mode == MODE_POP_FRONT) begin
                    agen_offset = IDX_W'(1);
                    front_next  = agen_slot;
                end
                if (req_mode == MODE_REMOVE_AT && !more_rd) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_SH_RD: begin
                agen_offset = k_reg + IDX_W'(1);
            end
            S_SH_WR: begin
                // read data of slot k+1 lands in slot k
                agen_offset   = k_reg;
                mem_req.we    = 1'b1;
                mem_req.wdata = mem_rdata;
                k_next        = k_reg + IDX_W'(1);
                if (!more_wr) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_valid_next          = 1'b1;
                    out_data_next.value_out = VALUE_W'(result_reg);
                    out_data_next.status    = status_reg;
                    out_data_next.count     = COUNT_W'(count_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        k_reg        <= k_next;
        result_reg   <= result_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/bounded_deque_with_indexed_access.sv
// Bounded deque with indexed access: top level.
//
// Holds up to DEPTH values in a circular RAM with one write and one registered read port.
// Each transaction on the s_ channel is one operation and gives exactly one result on the
// m_ channel. The block takes one transaction at a time. A push writes its slot in the execute
// step, a pop or read then waits for the registered read data, and a remove takes longer: every
// entry behind the removed one moves one slot toward the front through the one write and one
// read port of the RAM (read, then write). All slot addresses come from one shared modulo adder.
// A finished result sits in an output register, so a stalled result channel only holds the
// sequencer in its final step. Reset empties the deque at once; there is no clearing pass, and
// no RAM word is used in a result before it is written.
`default_nettype none

module bounded_deque_with_indexed_access (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bdq_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bdq_pkg::res_item_t m_data
);

    import bdq_pkg::*;

    logic [IDX_W-1:0]      agen_front;
    logic [IDX_W-1:0]      agen_offset;
    logic [IDX_W-1:0]      agen_slot;
    mem_req_t              mem_req;
    logic [DATA_WIDTH-1:0] mem_rdata;

    bdq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .agen_front  (agen_front),
        .agen_offset (agen_offset),
        .agen_slot   (agen_slot),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

    bdq_agen u_agen (
        .front  (agen_front),
        .offset (agen_offset),
        .slot   (agen_slot)
    );

    bdq_ram #(
        .ADDR_W (IDX_W),
        .DATA_W (DATA_WIDTH),
        .WORDS  (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// File: rtl/core/bdq_checker.sv
// Port-level checker for the deque, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module bdq_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire bdq_pkg::res_item_t m_data
);

    import bdq_pkg::*;

    logic s_fire;

    assign s_fire = s_valid && s_ready;

    // one transaction in flight: no acceptance in the cycle right after one
    `BDQ_ASSERT_NEXT(a_one_in_flight, s_fire, !s_ready, "accepted back to back")

    `BDQ_ASSERT_IMPL(a_count_bound, m_valid, m_data.count <= COUNT_W'(DEPTH),
        "count above depth")

    `BDQ_ASSERT_IMPL(a_full_count, m_valid && m_data.status == STAT_FULL,
        m_data.count == COUNT_W'(DEPTH), "full status with room left")

    `BDQ_ASSERT_IMPL(a_empty_result, m_valid && m_data.status == STAT_EMPTY,
        m_data.count == '0 && m_data.value_out == '0, "empty status with data")

    `BDQ_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_data),
        "result dropped or changed while stalled")

endmodule

bind bounded_deque_with_indexed_access bdq_checker u_bdq_checker (.*);

`default_nettype wire
